/* hw/rtl/tfs_pkg.sv */
// Shared types and constants for the three-level feedback scheduler.
// Holds the request, response and slot entry structs and the controller states.
// No dependencies.
package tfs_pkg;

   localparam int JobSlots   = 64;
   localparam int SlotW      = $clog2(JobSlots);
   localparam int CountW     = $clog2(JobSlots + 1);
   localparam int LevelCount = 3;

   typedef logic [SlotW-1:0]  slot_type;
   typedef logic [CountW-1:0] count_type;

   localparam logic       ACT_ADMIT        = 1'b0;
   localparam logic       ACT_TICK         = 1'b1;
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEVEL = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] LEVEL_TOP        = 2'd0;
   localparam logic [1:0] LEVEL_MID        = 2'd1;
   localparam logic [1:0] LEVEL_LOW        = 2'd2;
   localparam logic [1:0] LEVEL_INVALID    = 2'd3;
   localparam logic [1:0] CSR_QUANTUM0     = 2'd0;
   localparam logic [1:0] CSR_QUANTUM1     = 2'd1;
   localparam logic [1:0] CSR_QUANTUM2     = 2'd2;
   localparam logic [1:0] CSR_BOOST_WAIT   = 2'd3;

   typedef struct packed {
      logic        action;
      logic [7:0]  job_tag;
      logic [15:0] service_ticks;
      logic [1:0]  start_level;
   } req_type;

   typedef struct packed {
      logic [1:0]  admit_status;
      logic        finished_valid;
      logic [7:0]  finished_tag;
      logic        demoted_valid;
      logic        preempted_valid;
      logic        boost_done;
      logic        running_valid;
      logic [7:0]  running_tag;
      logic [1:0]  running_level;
      logic [31:0] tick_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] service;
      logic [15:0] quantum;
      logic [31:0] enq_time;
      logic [1:0]  level;
   } entry_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
      slot_type data;
   } link_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ADMIT, ST_RUN, ST_DISP, ST_POP, ST_B1, ST_B1C, ST_B2, ST_B2C,
      ST_PRD, ST_PWR, ST_SPLICE, ST_DONE
   } state_type;

endpackage

/* hw/rtl/three_level_feedback_scheduler.sv */
// Three-level feedback scheduler: slot memory, queue pointers and the controller.
// Admit requests pass through the admit state (rejected ones answer from idle); a tick
// runs the job, dispatches, checks boosts and promotes jobs one slot entry at a time.
// One request at a time; the response strobe rises in the cycle after the last step.
// Synchronous reset empties all queues, chains the free list, zeroes the tick counter
// and restores the default quanta and boost wait.
module three_level_feedback_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfs_pkg::req_type req_data,
   output logic             rsp_valid,
   output tfs_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import tfs_pkg::*;

   state_type   state_ff, state_in;
   logic [15:0] quantum0_ff, quantum1_ff, quantum2_ff, boost_wait_ff;
   slot_type    q_head_ff [LevelCount];
   slot_type    q_head_in [LevelCount];
   slot_type    q_tail_ff [LevelCount];
   slot_type    q_tail_in [LevelCount];
   count_type   q_count_ff [LevelCount];
   count_type   q_count_in [LevelCount];
   slot_type    free_head_ff, free_head_in;
   count_type   free_count_ff, free_count_in;
   logic        run_valid_ff, run_valid_in;
   slot_type    run_slot_ff, run_slot_in;
   logic [7:0]  run_tag_ff, run_tag_in;
   logic [1:0]  run_level_ff, run_level_in;
   logic [31:0] tick_ff, tick_in;
   logic        fin_v_ff, fin_v_in;
   logic [7:0]  fin_tag_ff, fin_tag_in;
   logic        dem_ff, dem_in;
   logic        pre_ff, pre_in;
   logic        boost_ff, boost_in;
   logic [1:0]  disp_q_ff, disp_q_in;
   logic [1:0]  prom_q_ff, prom_q_in;
   slot_type    walk_slot_ff, walk_slot_in;
   count_type   walk_left_ff, walk_left_in;
   req_type     req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   entry_type   entry_mem [JobSlots];
   entry_type   entry_rd_ff;
   logic        ent_we;
   slot_type    ent_waddr, ent_raddr;
   entry_type   ent_wdata;

   slot_type    lnk_raddr, lnk_rdata;
   link_wr_type lnk_wr;

   logic        respond;
   logic [1:0]  resp_status;
   logic        disp_found;
   logic [1:0]  disp_sel;
   logic [15:0] svc_dec, qnt_dec;
   logic        waited;
   logic [1:0]  new_level;

   function automatic logic [15:0] quantum_of(input logic [1:0] level,
                                               input logic [15:0] q0,
                                               input logic [15:0] q1,
                                               input logic [15:0] q2);
      logic [15:0] result;
      case (level)
         LEVEL_TOP: result = q0;
         LEVEL_MID: result = q1;
         default:   result = q2;
      endcase
      return result;
   endfunction

   tfs_link_mem u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (lnk_raddr),
      .wr      (lnk_wr),
      .rd_data (lnk_rdata)
   );

   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_waddr] <= ent_wdata;
      end
      entry_rd_ff <= entry_mem[ent_raddr];
   end

   assign svc_dec   = (entry_rd_ff.service != 16'd0) ? entry_rd_ff.service - 16'd1 : 16'd0;
   assign qnt_dec   = (entry_rd_ff.quantum != 16'd0) ? entry_rd_ff.quantum - 16'd1 : 16'd0;
   assign waited    = (tick_ff - entry_rd_ff.enq_time) >= {16'd0, boost_wait_ff};
   assign new_level = (entry_rd_ff.level != LEVEL_TOP) ? LEVEL_LOW : LEVEL_MID;

   always_comb begin
      disp_found = 1'b1;
      disp_sel   = LEVEL_TOP;
      if (q_count_ff[0] != '0) begin
         disp_sel = LEVEL_TOP;
      end else if (q_count_ff[1] != '0) begin
         disp_sel = LEVEL_MID;
      end else if (q_count_ff[2] != '0) begin
         disp_sel = LEVEL_LOW;
      end else begin
         disp_found = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      q_head_in     = q_head_ff;
      q_tail_in     = q_tail_ff;
      q_count_in    = q_count_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      run_valid_in  = run_valid_ff;
      run_slot_in   = run_slot_ff;
      run_tag_in    = run_tag_ff;
      run_level_in  = run_level_ff;
      tick_in       = tick_ff;
      fin_v_in      = fin_v_ff;
      fin_tag_in    = fin_tag_ff;
      dem_in        = dem_ff;
      pre_in        = pre_ff;
      boost_in      = boost_ff;
      disp_q_in     = disp_q_ff;
      prom_q_in     = prom_q_ff;
      walk_slot_in  = walk_slot_ff;
      walk_left_in  = walk_left_ff;
      req_in        = req_ff;
      ent_we        = 1'b0;
      ent_waddr     = run_slot_ff;
      ent_wdata     = entry_rd_ff;
      ent_raddr     = run_slot_ff;
      lnk_raddr     = free_head_ff;
      lnk_wr        = '0;
      respond       = 1'b0;
      resp_status   = STATUS_OK;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               fin_v_in   = 1'b0;
               fin_tag_in = 8'd0;
               dem_in     = 1'b0;
               pre_in     = 1'b0;
               boost_in   = 1'b0;
               if (req_data.action == ACT_TICK) begin
                  if (run_valid_ff) begin
                     ent_raddr = run_slot_ff;
                     state_in  = ST_RUN;
                  end else begin
                     state_in = ST_DISP;
                  end
               end else if (req_data.start_level == LEVEL_INVALID) begin
                  respond     = 1'b1;
                  resp_status = STATUS_BAD_LEVEL;
               end else if (free_count_ff == '0) begin
                  respond     = 1'b1;
                  resp_status = STATUS_FULL;
               end else begin
                  lnk_raddr = free_head_ff;
                  state_in  = ST_ADMIT;
               end
            end
         end
         ST_ADMIT: begin
            free_head_in  = lnk_rdata;
            free_count_in = free_count_ff - count_type'(1);
            ent_we        = 1'b1;
            ent_waddr     = free_head_ff;
            ent_wdata     = '{tag: req_ff.job_tag, service: req_ff.service_ticks,
                              quantum: quantum_of(req_ff.start_level, quantum0_ff,
                                                  quantum1_ff, quantum2_ff),
                              enq_time: tick_ff, level: req_ff.start_level};
            if (q_count_ff[req_ff.start_level] == '0) begin
               q_head_in[req_ff.start_level] = free_head_ff;
            end else begin
               lnk_wr = '{en: 1'b1, addr: q_tail_ff[req_ff.start_level], data: free_head_ff};
            end
            q_tail_in[req_ff.start_level]  = free_head_ff;
            q_count_in[req_ff.start_level] = q_count_ff[req_ff.start_level] + count_type'(1);
            respond  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_RUN: begin
            if (svc_dec == 16'd0) begin
               fin_v_in      = 1'b1;
               fin_tag_in    = entry_rd_ff.tag;
               lnk_wr        = '{en: 1'b1, addr: run_slot_ff, data: free_head_ff};
               free_head_in  = run_slot_ff;
               free_count_in = free_count_ff + count_type'(1);
               run_valid_in  = 1'b0;
            end else if (qnt_dec == 16'd0) begin
               dem_in    = 1'b1;
               ent_we    = 1'b1;
               ent_waddr = run_slot_ff;
               ent_wdata = '{tag: entry_rd_ff.tag, service: svc_dec,
                             quantum: quantum_of(new_level, quantum0_ff, quantum1_ff,
                                                 quantum2_ff),
                             enq_time: tick_ff, level: new_level};
               if (q_count_ff[new_level] == '0) begin
                  q_head_in[new_level] = run_slot_ff;
               end else begin
                  lnk_wr = '{en: 1'b1, addr: q_tail_ff[new_level], data: run_slot_ff};
               end
               q_tail_in[new_level]  = run_slot_ff;
               q_count_in[new_level] = q_count_ff[new_level] + count_type'(1);
               run_valid_in          = 1'b0;
            end else begin
               ent_we            = 1'b1;
               ent_waddr         = run_slot_ff;
               ent_wdata         = entry_rd_ff;
               ent_wdata.service = svc_dec;
               ent_wdata.quantum = qnt_dec;
            end
            state_in = ST_DISP;
         end
         ST_DISP: begin
            if (!disp_found) begin
               state_in = ST_B1;
            end else if (!run_valid_ff) begin
               ent_raddr = q_head_ff[disp_sel];
               lnk_raddr = q_head_ff[disp_sel];
               disp_q_in = disp_sel;
               state_in  = ST_POP;
            end else if (run_level_ff > disp_sel) begin
               pre_in = 1'b1;
               if (q_count_ff[run_level_ff] == '0) begin
                  q_tail_in[run_level_ff] = run_slot_ff;
               end else begin
                  lnk_wr = '{en: 1'b1, addr: run_slot_ff, data: q_head_ff[run_level_ff]};
               end
               q_head_in[run_level_ff]  = run_slot_ff;
               q_count_in[run_level_ff] = q_count_ff[run_level_ff] + count_type'(1);
               ent_raddr = q_head_ff[disp_sel];
               lnk_raddr = q_head_ff[disp_sel];
               disp_q_in = disp_sel;
               state_in  = ST_POP;
            end else begin
               state_in = ST_B1;
            end
         end
         ST_POP: begin
            q_count_in[disp_q_ff] = q_count_ff[disp_q_ff] - count_type'(1);
            if (q_count_ff[disp_q_ff] != count_type'(1)) begin
               q_head_in[disp_q_ff] = lnk_rdata;
            end
            run_slot_in  = q_head_ff[disp_q_ff];
            run_tag_in   = entry_rd_ff.tag;
            run_level_in = entry_rd_ff.level;
            run_valid_in = 1'b1;
            state_in     = ST_B1;
         end
         ST_B1: begin
            if (q_count_ff[1] != '0) begin
               ent_raddr = q_head_ff[1];
               state_in  = ST_B1C;
            end else begin
               state_in = ST_B2;
            end
         end
         ST_B1C: begin
            if (waited) begin
               boost_in     = 1'b1;
               prom_q_in    = LEVEL_MID;
               walk_slot_in = q_head_ff[1];
               walk_left_in = q_count_ff[1];
               state_in     = ST_PRD;
            end else begin
               state_in = ST_B2;
            end
         end
         ST_B2: begin
            if (q_count_ff[2] != '0) begin
               ent_raddr = q_head_ff[2];
               state_in  = ST_B2C;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_B2C: begin
            if (waited) begin
               boost_in     = 1'b1;
               prom_q_in    = LEVEL_LOW;
               walk_slot_in = q_head_ff[2];
               walk_left_in = q_count_ff[2];
               state_in     = ST_PRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PRD: begin
            ent_raddr = walk_slot_ff;
            lnk_raddr = walk_slot_ff;
            state_in  = ST_PWR;
         end
         ST_PWR: begin
            ent_we             = 1'b1;
            ent_waddr          = walk_slot_ff;
            ent_wdata          = entry_rd_ff;
            ent_wdata.level    = LEVEL_TOP;
            ent_wdata.quantum  = quantum0_ff;
            ent_wdata.enq_time = tick_ff;
            walk_slot_in       = lnk_rdata;
            walk_left_in       = walk_left_ff - count_type'(1);
            state_in           = (walk_left_ff == count_type'(1)) ? ST_SPLICE : ST_PRD;
         end
         ST_SPLICE: begin
            if (q_count_ff[0] == '0) begin
               q_head_in[0] = q_head_ff[prom_q_ff];
            end else begin
               lnk_wr = '{en: 1'b1, addr: q_tail_ff[0], data: q_head_ff[prom_q_ff]};
            end
            q_tail_in[0]          = q_tail_ff[prom_q_ff];
            q_count_in[0]         = q_count_ff[0] + q_count_ff[prom_q_ff];
            q_count_in[prom_q_ff] = '0;
            if (prom_q_ff == LEVEL_MID && q_count_ff[2] != '0) begin
               prom_q_in    = LEVEL_LOW;
               walk_slot_in = q_head_ff[2];
               walk_left_in = q_count_ff[2];
               state_in     = ST_PRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            tick_in  = tick_ff + 32'd1;
            respond  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (respond) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{admit_status: resp_status, finished_valid: fin_v_in,
                          finished_tag: fin_tag_in, demoted_valid: dem_in,
                          preempted_valid: pre_in, boost_done: boost_in,
                          running_valid: run_valid_in,
                          running_tag: run_valid_in ? run_tag_in : 8'd0,
                          running_level: run_valid_in ? run_level_in : 2'd0,
                          tick_count: tick_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum0_ff   <= 16'd2;
         quantum1_ff   <= 16'd4;
         quantum2_ff   <= 16'd8;
         boost_wait_ff <= 16'd32;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_QUANTUM0:   quantum0_ff   <= csr_data;
            CSR_QUANTUM1:   quantum1_ff   <= csr_data;
            CSR_QUANTUM2:   quantum2_ff   <= csr_data;
            CSR_BOOST_WAIT: boost_wait_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         q_head_ff     <= '{default: '0};
         q_tail_ff     <= '{default: '0};
         q_count_ff    <= '{default: '0};
         free_head_ff  <= '0;
         free_count_ff <= count_type'(JobSlots);
         run_valid_ff  <= 1'b0;
         run_slot_ff   <= '0;
         tick_ff       <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         q_head_ff     <= q_head_in;
         q_tail_ff     <= q_tail_in;
         q_count_ff    <= q_count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         run_valid_ff  <= run_valid_in;
         run_slot_ff   <= run_slot_in;
         tick_ff       <= tick_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_tag_ff   <= run_tag_in;
      run_level_ff <= run_level_in;
      fin_v_ff     <= fin_v_in;
      fin_tag_ff   <= fin_tag_in;
      dem_ff       <= dem_in;
      pre_ff       <= pre_in;
      boost_ff     <= boost_in;
      disp_q_ff    <= disp_q_in;
      prom_q_ff    <= prom_q_in;
      walk_slot_ff <= walk_slot_in;
      walk_left_ff <= walk_left_in;
      req_ff       <= req_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/tfs_link_mem.sv */
// Link memory of the scheduler slots, one read and one write port.
// Unwritten entries read as the reset free-list chain. Depends on tfs_pkg.
module tfs_link_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  tfs_pkg::slot_type    rd_addr,
   input  tfs_pkg::link_wr_type wr,
   output tfs_pkg::slot_type    rd_data
);
   import tfs_pkg::*;

   slot_type             mem [JobSlots];
   logic [JobSlots-1:0]  valid_ff;
   logic                 rd_valid_ff;
   slot_type             rd_word_ff;
   slot_type             rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_word_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff :
                    (rd_addr_ff == slot_type'(JobSlots - 1)) ? '0 :
                    rd_addr_ff + slot_type'(1);

endmodule
